// File: rtl/wpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpq_pkg: shared types and constants
// Sizes, codes and state machine type for the widest path query block.
// ----------------------------------------------------------------------------
package wpq_pkg;
    localparam int MaxVertices = 256;
    localparam int MaxEdges    = 1024;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);
    localparam int BW = 17;
    localparam logic [15:0] WeightCap     = 16'd65534;
    localparam logic [15:0] InfiniteWidth = 16'd65535;
    localparam logic [BW-1:0] SourceMark  = 17'h10000;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNREACH = 2'd1;
    localparam logic [1:0] ST_BADSRC  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_SCAN, S_PICK, S_RELAX, S_RELAX2, S_RD_TGT, S_DONE
    } t_state;
endpackage

// File: rtl/wpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpq_ram: generic single port RAM
// One access per cycle: an optional write plus a registered read (old data).
// ----------------------------------------------------------------------------
module wpq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: rtl/widest_path_query_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// widest_path_query_top: maximum bottleneck path search over a loaded graph
// Edge words are stored in an edge RAM; a query runs a Dijkstra style search
// with per vertex width/settled state held in a vertex RAM.
// Edge loads leave busy low; trivial queries go from accept through S_DONE to
//   the result strobe. Full search: init of every vertex, then per settled
//   vertex a scan, a pick and a sweep over all edges with a head vertex check
//   for each out edge of that vertex, then a last empty scan, a pick, a target
//   read and the result.
// One word at a time: busy is high from query accept until the result.
// The result strobe cannot stall.
// Reset (synchronous, active low) clears the state, edge and vertex counts and valid flags.
// ----------------------------------------------------------------------------
module widest_path_query_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [7:0]  i_node_a,
    input  logic [7:0]  i_node_b,
    input  logic [15:0] i_edge_weight,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_widest
);
    localparam int VW = wpq_pkg::VW;
    localparam int EW = wpq_pkg::EW;
    localparam int BW = wpq_pkg::BW;

    wpq_pkg::t_state r_state, n_state;

    logic [EW:0]   r_ecnt, n_ecnt;
    logic [VW:0]   r_vcnt, n_vcnt;
    logic [VW-1:0] r_src, r_tgt, n_src, n_tgt;
    logic [VW:0]   r_idx, n_idx;        // vertex scan / init index
    logic [EW:0]   r_eidx, n_eidx;      // edge sweep index
    logic [VW-1:0] r_u, n_u;            // vertex being settled
    logic [BW-1:0] r_bu, n_bu;
    logic          r_found, n_found;
    logic [VW-1:0] r_v, n_v;
    logic [BW-1:0] r_cand, n_cand;
    logic          r_vld, n_vld;
    logic          r_rdv, n_rdv;        // vertex read issued last cycle
    logic [VW-1:0] r_rdaddr, n_rdaddr;
    logic          r_ervld, n_ervld;    // edge read issued last cycle
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_ostat, n_ostat;
    logic [15:0]   r_owid, n_owid;

    // edge RAM: {tail, head, weight}
    logic          e_we;
    logic [EW-1:0] e_addr;
    logic [2*VW+15:0] e_wdata, e_rdata;
    // vertex RAM: {settled, width+1}
    logic          v_we;
    logic [VW-1:0] v_addr;
    logic [BW:0]   v_wdata, v_rdata;

    wpq_ram #(.Width(2*VW+16), .Depth(wpq_pkg::MaxEdges)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_addr(e_addr),
        .i_wdata(e_wdata), .o_rdata(e_rdata));
    wpq_ram #(.Width(BW+1), .Depth(wpq_pkg::MaxVertices)) u_vert_ram (
        .i_clk(i_clk), .i_we(v_we), .i_addr(v_addr),
        .i_wdata(v_wdata), .o_rdata(v_rdata));

    wire accept = start && !busy;
    assign busy = (r_state != wpq_pkg::S_IDLE);

    logic [15:0] w_sat;
    logic [VW:0] top;
    logic [BW-1:0] wplus;

    always_comb begin
        n_state = r_state; n_ecnt = r_ecnt; n_vcnt = r_vcnt;
        n_src = r_src; n_tgt = r_tgt; n_idx = r_idx; n_eidx = r_eidx;
        n_u = r_u; n_bu = r_bu; n_found = r_found; n_v = r_v; n_cand = r_cand;
        n_vld = r_vld; n_rdv = 1'b0; n_rdaddr = r_rdaddr; n_ervld = 1'b0;
        n_ovalid = 1'b0; n_ostat = r_ostat; n_owid = r_owid;
        e_we = 1'b0; e_addr = r_eidx[EW-1:0]; e_wdata = '0;
        v_we = 1'b0; v_addr = r_rdaddr; v_wdata = '0;
        w_sat = (i_edge_weight > wpq_pkg::WeightCap) ? wpq_pkg::WeightCap
                                                     : i_edge_weight;
        top = ({1'b0, (i_node_a > i_node_b) ? i_node_a : i_node_b}) + 1'b1;
        wplus = {1'b0, e_rdata[15:0]} + 1'b1;
        unique case (r_state)
            wpq_pkg::S_IDLE: begin
                if (accept) begin
                    if (!i_op) begin
                        if (r_ecnt < (EW+1)'(wpq_pkg::MaxEdges)) begin
                            e_we = 1'b1; e_addr = r_ecnt[EW-1:0];
                            e_wdata = {i_node_a, i_node_b, w_sat};
                            n_ecnt = r_ecnt + 1'b1;
                            if (top > r_vcnt) n_vcnt = top;
                        end
                    end else begin
                        n_src = i_node_a; n_tgt = i_node_b;
                        if ({1'b0, i_node_a} >= r_vcnt) begin
                            n_ostat = wpq_pkg::ST_BADSRC; n_owid = '0; n_state = wpq_pkg::S_DONE;
                        end else if (i_node_a == i_node_b) begin
                            n_ostat = wpq_pkg::ST_OK; n_owid = wpq_pkg::InfiniteWidth;
                            n_state = wpq_pkg::S_DONE;
                        end else if ({1'b0, i_node_b} >= r_vcnt) begin
                            n_ostat = wpq_pkg::ST_UNREACH; n_owid = '0; n_state = wpq_pkg::S_DONE;
                        end else begin
                            n_idx = '0; n_state = wpq_pkg::S_INIT;
                        end
                    end
                end
            end
            wpq_pkg::S_INIT: begin
                v_we = 1'b1; v_addr = r_idx[VW-1:0];
                v_wdata = (r_idx[VW-1:0] == r_src) ? {1'b0, wpq_pkg::SourceMark} : '0;
                if (r_idx + 1'b1 >= r_vcnt) begin
                    n_idx = '0; n_bu = '0; n_found = 1'b0; n_state = wpq_pkg::S_SCAN;
                end else n_idx = r_idx + 1'b1;
            end
            wpq_pkg::S_SCAN: begin
                // pipelined read: issue address r_idx, compare previous data
                if (r_rdv && !v_rdata[BW] && v_rdata[BW-1:0] > r_bu) begin
                    n_bu = v_rdata[BW-1:0]; n_u = r_rdaddr; n_found = 1'b1;
                end
                if (r_idx < r_vcnt) begin
                    v_addr = r_idx[VW-1:0]; n_rdaddr = r_idx[VW-1:0];
                    n_rdv = 1'b1; n_idx = r_idx + 1'b1;
                end else if (!r_rdv) begin
                    n_state = wpq_pkg::S_PICK;
                end
            end
            wpq_pkg::S_PICK: begin
                if (!r_found) begin
                    n_rdaddr = r_tgt; n_state = wpq_pkg::S_RD_TGT;
                end else begin
                    v_we = 1'b1; v_addr = r_u; v_wdata = {1'b1, r_bu};
                    n_eidx = '0; n_state = wpq_pkg::S_RELAX;
                end
            end
            wpq_pkg::S_RELAX: begin
                // read edge, next cycle read head vertex
                if (r_ervld) begin
                    n_v = e_rdata[15 +: VW];
                    n_cand = (wplus > r_bu) ? r_bu : wplus;
                    if (e_rdata[16+VW +: VW] == r_u &&
                        {1'b0, e_rdata[15+1 +: VW]} < r_vcnt) begin
                        v_addr = e_rdata[16 +: VW]; n_rdaddr = e_rdata[16 +: VW];
                        n_v = e_rdata[16 +: VW];
                        n_state = wpq_pkg::S_RELAX2;
                    end
                end
                if (n_state == wpq_pkg::S_RELAX) begin
                    if (r_eidx < r_ecnt) begin
                        e_addr = r_eidx[EW-1:0]; n_eidx = r_eidx + 1'b1; n_ervld = 1'b1;
                    end else if (!r_ervld) begin
                        n_idx = '0; n_bu = '0; n_found = 1'b0; n_state = wpq_pkg::S_SCAN;
                    end
                end
            end
            wpq_pkg::S_RELAX2: begin
                if (!v_rdata[BW] && r_cand > v_rdata[BW-1:0]) begin
                    v_we = 1'b1; v_addr = r_v; v_wdata = {1'b0, r_cand};
                end
                n_state = wpq_pkg::S_RELAX;
            end
            wpq_pkg::S_RD_TGT: begin
                v_addr = r_tgt;
                if (r_rdv) begin
                    if (v_rdata[BW-1:0] == '0) begin
                        n_ostat = wpq_pkg::ST_UNREACH; n_owid = '0;
                    end else begin
                        n_ostat = wpq_pkg::ST_OK; n_owid = 16'(v_rdata[BW-1:0] - 1'b1);
                    end
                    n_state = wpq_pkg::S_DONE;
                end else n_rdv = 1'b1;
            end
            wpq_pkg::S_DONE: begin
                n_ovalid = 1'b1; n_state = wpq_pkg::S_IDLE;
            end
            default: n_state = wpq_pkg::S_IDLE;
        endcase
        n_vld = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpq_pkg::S_IDLE; r_ecnt <= '0; r_vcnt <= '0;
            r_rdv <= 1'b0; r_ervld <= 1'b0; r_ovalid <= 1'b0; r_vld <= 1'b0;
        end else begin
            r_state <= n_state; r_ecnt <= n_ecnt; r_vcnt <= n_vcnt;
            r_rdv <= n_rdv; r_ervld <= n_ervld; r_ovalid <= n_ovalid; r_vld <= n_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_src <= n_src; r_tgt <= n_tgt; r_idx <= n_idx; r_eidx <= n_eidx;
        r_u <= n_u; r_bu <= n_bu; r_found <= n_found; r_v <= n_v;
        r_cand <= n_cand; r_rdaddr <= n_rdaddr; r_ostat <= n_ostat; r_owid <= n_owid;
    end

    assign o_valid  = r_ovalid && !r_vld;
    assign o_status = r_ostat;
    assign o_widest = r_owid;

    // a result only follows the last cycle of a query
    a_res_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == wpq_pkg::S_DONE)) else $error("stray result");
    // edge count never shrinks outside reset
    a_ecnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_ecnt >= $past(r_ecnt)) else $error("edge count fell");
    // loads only happen while idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_we |-> r_state == wpq_pkg::S_IDLE) else $error("edge write while busy");
endmodule
